>>> hw/rtl/nfcs_pkg.sv
// ----------------------------------------------------------------------------
// nfcs_pkg
// Shared types and constants of the NAND flash command sequencer: bus cycle
// kinds, opcodes, session modes, sequencer step positions and the job word.
// ----------------------------------------------------------------------------
package nfcs_pkg;

    localparam int PAGE_BYTES       = 2048;
    localparam int BLOCK_BYTES      = 131072;
    localparam int MAX_ERASE_BLOCKS = 8;

    localparam int ADDR_W   = 28;
    localparam int LEN_W    = 29;
    localparam int ROW_W    = 17;
    localparam int PAGE_SH  = $clog2(PAGE_BYTES);
    localparam int BLK_SH   = $clog2(BLOCK_BYTES);
    localparam int COL_W    = PAGE_SH + 1;
    localparam int BLK_W    = $clog2(MAX_ERASE_BLOCKS + 1);
    localparam int ROWS_PER_BLOCK = BLOCK_BYTES / PAGE_BYTES;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        KIND_SELECT   = 3'd0,
        KIND_CMD      = 3'd1,
        KIND_ADDR     = 3'd2,
        KIND_DWRITE   = 3'd3,
        KIND_DREAD    = 3'd4,
        KIND_WAIT     = 3'd5,
        KIND_DESELECT = 3'd6,
        KIND_ERROR    = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        OP_BEGIN_READ = 3'd0,
        OP_READ_BYTE  = 3'd1,
        OP_BEGIN_PROG = 3'd2,
        OP_WRITE_BYTE = 3'd3,
        OP_ERASE      = 3'd4,
        OP_READ_ID    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_READ = 3'b010,
        MODE_PROG = 3'b100
    } mode_t;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MISALIGN  = 2'd1;
    localparam logic [1:0] ERR_BAD_LEN   = 2'd2;

    localparam logic [7:0] CMD_READ      = 8'h00;
    localparam logic [7:0] CMD_READ_GO   = 8'h30;
    localparam logic [7:0] CMD_PROG      = 8'h80;
    localparam logic [7:0] CMD_PROG_GO   = 8'h10;
    localparam logic [7:0] CMD_ERASE     = 8'h60;
    localparam logic [7:0] CMD_ERASE_GO  = 8'hD0;
    localparam logic [7:0] CMD_READ_ID   = 8'h90;

    // step positions, emitted from low to high
    localparam int NUM_STEPS   = 17;
    localparam int STEP_W      = $clog2(NUM_STEPS);
    localparam int ST_PRE_DESEL = 0;
    localparam int ST_SELECT    = 1;
    localparam int ST_ERROR     = 2;
    localparam int ST_FIN_A_CMD = 3;
    localparam int ST_FIN_A_WT  = 4;
    localparam int ST_SETUP     = 5;
    localparam int ST_COL0      = 6;
    localparam int ST_COL1      = 7;
    localparam int ST_ROW0      = 8;
    localparam int ST_ROW1      = 9;
    localparam int ST_ROW2      = 10;
    localparam int ST_END       = 11;
    localparam int ST_SETUP_WT  = 12;
    localparam int ST_DATA      = 13;
    localparam int ST_FIN_B_CMD = 14;
    localparam int ST_FIN_B_WT  = 15;
    localparam int ST_DESEL     = 16;

    typedef logic [NUM_STEPS-1:0] step_mask_t;

    localparam step_mask_t M_PRE_DESEL = step_mask_t'(1) << ST_PRE_DESEL;
    localparam step_mask_t M_SELECT    = step_mask_t'(1) << ST_SELECT;
    localparam step_mask_t M_ERROR     = step_mask_t'(1) << ST_ERROR;
    localparam step_mask_t M_SETUP     = step_mask_t'(1) << ST_SETUP;
    localparam step_mask_t M_COL0      = step_mask_t'(1) << ST_COL0;
    localparam step_mask_t M_DATA      = step_mask_t'(1) << ST_DATA;
    localparam step_mask_t M_DESEL     = step_mask_t'(1) << ST_DESEL;
    localparam step_mask_t M_FIN_A     = (step_mask_t'(1) << ST_FIN_A_CMD)
                                       | (step_mask_t'(1) << ST_FIN_A_WT);
    localparam step_mask_t M_FIN_B     = (step_mask_t'(1) << ST_FIN_B_CMD)
                                       | (step_mask_t'(1) << ST_FIN_B_WT);
    localparam step_mask_t M_ROWS      = (step_mask_t'(1) << ST_ROW0)
                                       | (step_mask_t'(1) << ST_ROW1)
                                       | (step_mask_t'(1) << ST_ROW2);
    localparam step_mask_t M_COLS      = M_COL0 | (step_mask_t'(1) << ST_COL1);
    localparam step_mask_t M_GO        = (step_mask_t'(1) << ST_END)
                                       | (step_mask_t'(1) << ST_SETUP_WT);
    localparam step_mask_t M_PROG_SETUP = M_SETUP | M_COLS | M_ROWS;
    localparam step_mask_t M_READ_SETUP = M_PROG_SETUP | M_GO;
    localparam step_mask_t M_ERASE_BLK  = M_SETUP | M_ROWS | M_GO;

    typedef struct packed {
        step_mask_t         mask;
        logic [7:0]         setup_cmd;
        logic [7:0]         end_cmd;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [BLK_W-1:0]   blocks;
        logic [2:0]         data_count;
        logic               data_write;
        logic [7:0]         data_value;
        logic [1:0]         err_code;
    } job_t;

endpackage

>>> hw/rtl/nfcs_front.sv
// ----------------------------------------------------------------------------
// nfcs_front
// Accepts operations, tracks the open read or program session and turns each
// operation into a job word that lists the bus cycle steps to run.
// ----------------------------------------------------------------------------
module nfcs_front
    import nfcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        opcode,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  length,
    input  logic [7:0]        write_data,
    output logic              job_push,
    output job_t              job
);

    mode_t             mode_reg, mode_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;

    always_comb
    begin
        logic              pre;
        logic              wrap;
        logic [ROW_W-1:0]  row_use;
        logic [COL_W-1:0]  col_use;
        logic [LEN_W-1:0]  rem_dec;
        logic [ROW_W-1:0]  addr_row;
        logic [COL_W-1:0]  addr_col;
        logic              misalign;
        logic              bad_len;

        pre      = (mode_reg != MODE_IDLE);
        wrap     = (column_reg >= COL_W'(PAGE_BYTES));
        row_use  = wrap ? row_reg + 1'b1 : row_reg;
        col_use  = wrap ? '0 : column_reg;
        rem_dec  = remain_reg - 1'b1;
        addr_row = ROW_W'(address >> PAGE_SH);
        addr_col = COL_W'(address[PAGE_SH-1:0]);
        misalign = (address[BLK_SH-1:0] != '0);
        bad_len  = (length == '0) || (length[BLK_SH-1:0] != '0)
                 || ((length >> BLK_SH) > LEN_W'(MAX_ERASE_BLOCKS));

        mode_next   = mode_reg;
        row_next    = row_reg;
        column_next = column_reg;
        remain_next = remain_reg;

        job            = '0;
        job.blocks     = BLK_W'(1);
        job.data_count = 3'd1;
        job.end_cmd    = CMD_READ_GO;

        case (opcode)
            OP_BEGIN_READ:
            begin
                job.mask      = (pre ? M_PRE_DESEL : '0) | M_SELECT | M_READ_SETUP
                              | ((length == '0) ? M_DESEL : '0);
                job.setup_cmd = CMD_READ;
                job.row       = addr_row;
                job.column    = addr_col;
                row_next      = addr_row;
                column_next   = addr_col;
                remain_next   = length;
                mode_next     = (length == '0) ? MODE_IDLE : MODE_READ;
            end
            OP_READ_BYTE:
            begin
                if (mode_reg == MODE_READ)
                begin
                    job.mask      = (wrap ? M_READ_SETUP : '0) | M_DATA
                                  | ((rem_dec == '0) ? M_DESEL : '0);
                    job.setup_cmd = CMD_READ;
                    job.row       = row_use;
                    job.column    = col_use;
                    row_next      = row_use;
                    column_next   = col_use + 1'b1;
                    remain_next   = rem_dec;
                    mode_next     = (rem_dec == '0) ? MODE_IDLE : MODE_READ;
                end
            end
            OP_BEGIN_PROG:
            begin
                job.mask      = (pre ? M_PRE_DESEL : '0) | M_SELECT | M_PROG_SETUP
                              | ((length == '0) ? (M_FIN_B | M_DESEL) : '0);
                job.setup_cmd = CMD_PROG;
                job.row       = addr_row;
                job.column    = addr_col;
                row_next      = addr_row;
                column_next   = addr_col;
                remain_next   = length;
                mode_next     = (length == '0) ? MODE_IDLE : MODE_PROG;
            end
            OP_WRITE_BYTE:
            begin
                if (mode_reg == MODE_PROG)
                begin
                    job.mask       = (wrap ? (M_FIN_A | M_PROG_SETUP) : '0) | M_DATA
                                   | ((rem_dec == '0) ? (M_FIN_B | M_DESEL) : '0);
                    job.setup_cmd  = CMD_PROG;
                    job.row        = row_use;
                    job.column     = col_use;
                    job.data_write = 1'b1;
                    job.data_value = write_data;
                    row_next       = row_use;
                    column_next    = col_use + 1'b1;
                    remain_next    = rem_dec;
                    mode_next      = (rem_dec == '0) ? MODE_IDLE : MODE_PROG;
                end
            end
            OP_ERASE:
            begin
                mode_next = MODE_IDLE;
                if (misalign)
                begin
                    job.mask     = (pre ? M_PRE_DESEL : '0) | M_ERROR;
                    job.err_code = ERR_MISALIGN;
                end
                else if (bad_len)
                begin
                    job.mask     = (pre ? M_PRE_DESEL : '0) | M_ERROR;
                    job.err_code = ERR_BAD_LEN;
                end
                else
                begin
                    job.mask      = (pre ? M_PRE_DESEL : '0) | M_SELECT | M_ERASE_BLK
                                  | M_DESEL;
                    job.setup_cmd = CMD_ERASE;
                    job.end_cmd   = CMD_ERASE_GO;
                    job.row       = addr_row;
                    job.blocks    = BLK_W'(length >> BLK_SH);
                end
            end
            OP_READ_ID:
            begin
                mode_next      = MODE_IDLE;
                job.mask       = (pre ? M_PRE_DESEL : '0) | M_SELECT | M_SETUP | M_COL0
                               | M_DATA | M_DESEL;
                job.setup_cmd  = CMD_READ_ID;
                job.data_count = 3'd5;
            end
            default:
            begin
                job.mask = '0;
            end
        endcase

        job_push = accept && (job.mask != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            row_reg    <= '0;
            column_reg <= '0;
            remain_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            row_reg    <= row_next;
            column_reg <= column_next;
            remain_reg <= remain_next;
        end
    end

endmodule

>>> hw/rtl/nfcs_queue.sv
// ----------------------------------------------------------------------------
// nfcs_queue
// Short first-in first-out queue of job words between the front and the
// back sequencer.
// ----------------------------------------------------------------------------
module nfcs_queue
    import nfcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output logic rd_valid,
    output job_t rd_job
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign q_full   = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/nfcs_back.sv
// ----------------------------------------------------------------------------
// nfcs_back
// Sequencer that runs one job word at a time, one bus cycle word per clock
// while the output register is free or being popped, into a single output register.
// ----------------------------------------------------------------------------
module nfcs_back
    import nfcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_pop,
    input  logic       pop,
    output logic       empty,
    output logic [2:0] cycle_kind,
    output logic [7:0] cycle_value,
    output logic [1:0] error_code,
    output logic       last
);

    step_mask_t        mask_reg, mask_next;
    logic [7:0]        setup_cmd_reg;
    logic [7:0]        end_cmd_reg;
    logic [COL_W-1:0]  column_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [BLK_W-1:0]  blocks_reg, blocks_next;
    logic [2:0]        count_reg, count_next;
    logic              data_write_reg;
    logic [7:0]        data_value_reg;
    logic [1:0]        err_code_reg;

    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [7:0]        value_reg;
    logic [1:0]        err_reg;
    logic              last_reg;

    logic              advance;
    logic              load;
    logic [STEP_W-1:0] cur_step;
    kind_t             kind_now;
    logic [7:0]        value_now;
    logic [1:0]        err_now;
    logic [15:0]       col_wide;
    logic [23:0]       row_wide;

    assign advance  = (mask_reg != '0) && (!out_valid_reg || pop);
    assign load     = job_valid && ((mask_reg == '0) || (advance && (mask_next == '0)));
    assign job_pop  = load;
    assign col_wide = 16'(column_reg);
    assign row_wide = 24'(row_reg);

    always_comb
    begin
        cur_step = '0;
        for (int i = NUM_STEPS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                cur_step = STEP_W'(i);
            end
        end
    end

    always_comb
    begin
        mask_next   = mask_reg;
        mask_next[cur_step] = 1'b0;
        row_next    = row_reg;
        blocks_next = blocks_reg;
        count_next  = count_reg;
        kind_now    = KIND_DESELECT;
        value_now   = '0;
        err_now     = ERR_NONE;

        case (cur_step)
            STEP_W'(ST_PRE_DESEL): kind_now = KIND_DESELECT;
            STEP_W'(ST_SELECT):    kind_now = KIND_SELECT;
            STEP_W'(ST_ERROR):
            begin
                kind_now = KIND_ERROR;
                err_now  = err_code_reg;
            end
            STEP_W'(ST_FIN_A_CMD), STEP_W'(ST_FIN_B_CMD):
            begin
                kind_now  = KIND_CMD;
                value_now = CMD_PROG_GO;
            end
            STEP_W'(ST_FIN_A_WT), STEP_W'(ST_FIN_B_WT):
            begin
                kind_now = KIND_WAIT;
            end
            STEP_W'(ST_SETUP):
            begin
                kind_now  = KIND_CMD;
                value_now = setup_cmd_reg;
            end
            STEP_W'(ST_COL0):
            begin
                kind_now  = KIND_ADDR;
                value_now = col_wide[7:0];
            end
            STEP_W'(ST_COL1):
            begin
                kind_now  = KIND_ADDR;
                value_now = col_wide[15:8];
            end
            STEP_W'(ST_ROW0):
            begin
                kind_now  = KIND_ADDR;
                value_now = row_wide[7:0];
            end
            STEP_W'(ST_ROW1):
            begin
                kind_now  = KIND_ADDR;
                value_now = row_wide[15:8];
            end
            STEP_W'(ST_ROW2):
            begin
                kind_now  = KIND_ADDR;
                value_now = row_wide[23:16];
            end
            STEP_W'(ST_END):
            begin
                kind_now  = KIND_CMD;
                value_now = end_cmd_reg;
            end
            STEP_W'(ST_SETUP_WT):
            begin
                kind_now = KIND_WAIT;
                // next erase block
                if (blocks_reg > BLK_W'(1))
                begin
                    mask_next   = mask_next | M_ERASE_BLK;
                    blocks_next = blocks_reg - 1'b1;
                    row_next    = row_reg + ROW_W'(ROWS_PER_BLOCK);
                end
            end
            STEP_W'(ST_DATA):
            begin
                kind_now  = data_write_reg ? KIND_DWRITE : KIND_DREAD;
                value_now = data_write_reg ? data_value_reg : 8'h00;
                if (count_reg > 3'd1)
                begin
                    mask_next[cur_step] = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            STEP_W'(ST_DESEL):     kind_now = KIND_DESELECT;
            default:               kind_now = KIND_DESELECT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            setup_cmd_reg  <= job.setup_cmd;
            end_cmd_reg    <= job.end_cmd;
            column_reg     <= job.column;
            row_reg        <= job.row;
            blocks_reg     <= job.blocks;
            count_reg      <= job.data_count;
            data_write_reg <= job.data_write;
            data_value_reg <= job.data_value;
            err_code_reg   <= job.err_code;
        end
        else if (advance)
        begin
            row_reg    <= row_next;
            blocks_reg <= blocks_next;
            count_reg  <= count_next;
        end
        if (advance)
        begin
            kind_reg  <= kind_now;
            value_reg <= value_now;
            err_reg   <= err_now;
            last_reg  <= (mask_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mask_reg <= job.mask;
            end
            else if (advance)
            begin
                mask_reg <= mask_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign cycle_kind  = kind_reg;
    assign cycle_value = value_reg;
    assign error_code  = err_reg;
    assign last        = last_reg;

endmodule

>>> hw/rtl/nand_flash_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// nand_flash_command_sequencer_unit
// path: first word of an operation passes the job queue, then the back
//   sequencer's job registers, then its output register
// throughput: one operation per cycle enters while the four-deep job queue has
//   room; words leave one per cycle while pop is held (1 to 51 per operation)
// reset: session closed, job queue and output register empty
// ----------------------------------------------------------------------------
module nand_flash_command_sequencer_unit
    import nfcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        opcode,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  length,
    input  logic [7:0]        write_data,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        cycle_kind,
    output logic [7:0]        cycle_value,
    output logic [1:0]        error_code,
    output logic              last
);

    logic accept;
    logic job_push;
    job_t front_job;
    logic q_valid;
    job_t q_job;
    logic q_pop;

    assign accept = push && !full;

    nfcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .address    (address),
        .length     (length),
        .write_data (write_data),
        .job_push   (job_push),
        .job        (front_job)
    );

    nfcs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (front_job),
        .q_full   (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_job   (q_job)
    );

    nfcs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (q_job),
        .job_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .cycle_kind  (cycle_kind),
        .cycle_value (cycle_value),
        .error_code  (error_code),
        .last        (last)
    );

endmodule

>>> tb/nfcs_bus_cycle_checker.sv
// ----------------------------------------------------------------------------
// nfcs_bus_cycle_checker
// Watches the operation queue and the bus cycle queue of the NAND flash
// command sequencer. It keeps its own copy of the session state, turns each
// accepted operation into the list of bus cycle words it should cause, and
// compares every popped word field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module nfcs_bus_cycle_checker
    import nfcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [2:0]        opcode,
    input  logic [ADDR_W-1:0] address,
    input  logic [LEN_W-1:0]  length,
    input  logic [7:0]        write_data,
    input  logic              empty,
    input  logic              pop,
    input  logic [2:0]        cycle_kind,
    input  logic [7:0]        cycle_value,
    input  logic [1:0]        error_code,
    input  logic              last,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [1:0] err;
        logic       last;
    } bus_word_t;

    bus_word_t owed_words[$];
    bus_word_t op_words[$];

    mode_t             sess_mode;
    logic [ROW_W-1:0]  sess_row;
    logic [COL_W-1:0]  sess_col;
    logic [LEN_W-1:0]  sess_left;

    function void put(kind_t k, logic [7:0] v, logic [1:0] e);
        bus_word_t w;
        w.kind  = k;
        w.value = v;
        w.err   = e;
        w.last  = 1'b0;
        op_words.push_back(w);
    endfunction

    function void put_row(logic [ROW_W-1:0] r);
        put(KIND_ADDR, r[7:0], ERR_NONE);
        put(KIND_ADDR, r[15:8], ERR_NONE);
        put(KIND_ADDR, 8'(r >> 16), ERR_NONE);
    endfunction

    function void put_page_addr();
        put(KIND_ADDR, sess_col[7:0], ERR_NONE);
        put(KIND_ADDR, 8'(sess_col >> 8), ERR_NONE);
        put_row(sess_row);
    endfunction

    function void put_read_setup();
        put(KIND_CMD, CMD_READ, ERR_NONE);
        put_page_addr();
        put(KIND_CMD, CMD_READ_GO, ERR_NONE);
        put(KIND_WAIT, 8'h00, ERR_NONE);
    endfunction

    function void put_prog_setup();
        put(KIND_CMD, CMD_PROG, ERR_NONE);
        put_page_addr();
    endfunction

    function void put_prog_close();
        put(KIND_CMD, CMD_PROG_GO, ERR_NONE);
        put(KIND_WAIT, 8'h00, ERR_NONE);
    endfunction

    function void open_session(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] n);
        sess_row  = ROW_W'(a >> PAGE_SH);
        sess_col  = COL_W'(a[PAGE_SH-1:0]);
        sess_left = n;
    endfunction

    function void next_page();
        sess_col = '0;
        sess_row = sess_row + 1'b1;
    endfunction

    function void predict_words(logic [2:0] op, logic [ADDR_W-1:0] a,
                                logic [LEN_W-1:0] n, logic [7:0] d);
        int unsigned blocks;
        int unsigned blk_addr;
        bus_word_t   w;
        op_words.delete();
        // a new operation drops an open session
        if ((op == OP_BEGIN_READ || op == OP_BEGIN_PROG || op == OP_ERASE ||
             op == OP_READ_ID) && sess_mode != MODE_IDLE)
        begin
            put(KIND_DESELECT, 8'h00, ERR_NONE);
            sess_mode = MODE_IDLE;
        end
        case (op)
            OP_BEGIN_READ:
            begin
                open_session(a, n);
                put(KIND_SELECT, 8'h00, ERR_NONE);
                put_read_setup();
                if (n == 0)
                    put(KIND_DESELECT, 8'h00, ERR_NONE);
                else
                    sess_mode = MODE_READ;
            end
            OP_READ_BYTE:
            begin
                if (sess_mode == MODE_READ)
                begin
                    if (sess_col >= PAGE_BYTES)
                    begin
                        next_page();
                        put_read_setup();
                    end
                    put(KIND_DREAD, 8'h00, ERR_NONE);
                    sess_col  = sess_col + 1'b1;
                    sess_left = sess_left - 1'b1;
                    if (sess_left == 0)
                    begin
                        put(KIND_DESELECT, 8'h00, ERR_NONE);
                        sess_mode = MODE_IDLE;
                    end
                end
            end
            OP_BEGIN_PROG:
            begin
                open_session(a, n);
                put(KIND_SELECT, 8'h00, ERR_NONE);
                put_prog_setup();
                if (n == 0)
                begin
                    put_prog_close();
                    put(KIND_DESELECT, 8'h00, ERR_NONE);
                end
                else
                    sess_mode = MODE_PROG;
            end
            OP_WRITE_BYTE:
            begin
                if (sess_mode == MODE_PROG)
                begin
                    if (sess_col >= PAGE_BYTES)
                    begin
                        put_prog_close();
                        next_page();
                        put_prog_setup();
                    end
                    put(KIND_DWRITE, d, ERR_NONE);
                    sess_col  = sess_col + 1'b1;
                    sess_left = sess_left - 1'b1;
                    if (sess_left == 0)
                    begin
                        put_prog_close();
                        put(KIND_DESELECT, 8'h00, ERR_NONE);
                        sess_mode = MODE_IDLE;
                    end
                end
            end
            OP_ERASE:
            begin
                blocks = n / BLOCK_BYTES;
                if (a % BLOCK_BYTES != 0)
                    put(KIND_ERROR, 8'h00, ERR_MISALIGN);
                else if (n == 0 || n % BLOCK_BYTES != 0 || blocks > MAX_ERASE_BLOCKS)
                    put(KIND_ERROR, 8'h00, ERR_BAD_LEN);
                else
                begin
                    put(KIND_SELECT, 8'h00, ERR_NONE);
                    for (int k = 0; k < blocks; k++)
                    begin
                        blk_addr = a + k * BLOCK_BYTES;
                        put(KIND_CMD, CMD_ERASE, ERR_NONE);
                        put_row(ROW_W'(blk_addr >> PAGE_SH));
                        put(KIND_CMD, CMD_ERASE_GO, ERR_NONE);
                        put(KIND_WAIT, 8'h00, ERR_NONE);
                    end
                    put(KIND_DESELECT, 8'h00, ERR_NONE);
                end
            end
            OP_READ_ID:
            begin
                put(KIND_SELECT, 8'h00, ERR_NONE);
                put(KIND_CMD, CMD_READ_ID, ERR_NONE);
                put(KIND_ADDR, 8'h00, ERR_NONE);
                for (int k = 0; k < 5; k++)
                    put(KIND_DREAD, 8'h00, ERR_NONE);
                put(KIND_DESELECT, 8'h00, ERR_NONE);
            end
            default:
            begin
            end
        endcase
        if (op_words.size() > 0)
        begin
            w = op_words.pop_back();
            w.last = 1'b1;
            op_words.push_back(w);
        end
        foreach (op_words[i])
            owed_words.push_back(op_words[i]);
    endfunction

    function void check_word();
        bus_word_t w;
        if (owed_words.size() == 0)
        begin
            $error("unexpected word: kind %0d value %0h err %0d last %0b",
                   cycle_kind, cycle_value, error_code, last);
            fail_count++;
        end
        else
        begin
            w = owed_words.pop_front();
            if (cycle_kind !== w.kind)
            begin
                $error("cycle_kind expected %0d actual %0d", w.kind, cycle_kind);
                fail_count++;
            end
            if (cycle_value !== w.value)
            begin
                $error("cycle_value expected %0h actual %0h", w.value, cycle_value);
                fail_count++;
            end
            if (error_code !== w.err)
            begin
                $error("error_code expected %0d actual %0d", w.err, error_code);
                fail_count++;
            end
            if (last !== w.last)
            begin
                $error("last expected %0b actual %0b", w.last, last);
                fail_count++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_mode  = MODE_IDLE;
            sess_row   = '0;
            sess_col   = '0;
            sess_left  = '0;
            owed_words.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (pop && !empty)
                check_word();
            if (push && !full)
                predict_words(opcode, address, length, write_data);
            pending = owed_words.size();
        end
    end

endmodule

>>> tb/tb_nand_flash_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_nand_flash_command_sequencer_unit
// Drives flash operations into the sequencer and drains its bus cycle words
// with random gaps on both sides and one long receiver hold-off. A directed
// list covers erase checks, zero lengths, page crossing, row wrap and
// interrupted sessions; random sessions, erases and noise follow. Checking
// is done by the bus cycle checker.
// ----------------------------------------------------------------------------
module tb_nand_flash_command_sequencer_unit;
    import nfcs_pkg::*;

    localparam int          ITEMS       = 480;
    localparam int          QUIET_LIMIT = 3000;
    localparam int          HOLD_AFTER  = 200;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [2:0]  OP_SPARE_6  = 3'd6;
    localparam logic [2:0]  OP_SPARE_7  = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [2:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [7:0]        write_data;
    logic              empty;
    logic              pop;
    logic [2:0]        cycle_kind;
    logic [7:0]        cycle_value;
    logic [1:0]        error_code;
    logic              last;
    int                fail_count;
    int                pending;

    int                items_sent;
    int                counted;
    int                quiet;
    bit                calm;

    nand_flash_command_sequencer_unit i_dut (.*);

    nfcs_bus_cycle_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_op(input logic [2:0] op, input logic [ADDR_W-1:0] a,
                           input logic [LEN_W-1:0] n, input logic [7:0] d);
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        opcode     <= op;
        address    <= a;
        length     <= n;
        write_data <= d;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic run_session(input bit prog);
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  n;
        int unsigned       bytes;
        int                r;
        a = ADDR_W'($urandom);
        // start near the page end so that short sessions cross pages
        if ($urandom_range(0, 1))
            a[PAGE_SH-1:0] = PAGE_SH'(PAGE_BYTES - $urandom_range(1, 6));
        r = $urandom_range(0, 99);
        if (r < 10)
            n = '0;
        else if (r < 18)
            n = LEN_W'($urandom_range(0, 1 << 28));
        else
            n = LEN_W'($urandom_range(1, 20));
        if (n > 20)
            bytes = $urandom_range(0, 10);
        else if ($urandom_range(0, 99) < 15)
            bytes = $urandom_range(0, n + 3);
        else
            bytes = n;
        send_op(prog ? OP_BEGIN_PROG : OP_BEGIN_READ, a, n, 8'($urandom));
        counted++;
        for (int i = 0; i < bytes; i++)
        begin
            send_op(prog ? OP_WRITE_BYTE : OP_READ_BYTE, ADDR_W'($urandom),
                    LEN_W'($urandom), 8'($urandom));
            if (i < n)
                counted++;
        end
    endtask

    // receiver
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && items_sent >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= calm || $urandom_range(0, 99) >= 22;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet <= 0;
            else if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int r;
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        opcode     = '0;
        address    = '0;
        length     = '0;
        write_data = '0;
        items_sent = 0;
        counted    = 0;
        quiet      = 0;
        calm       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_op(OP_READ_ID, '0, '0, 8'h00);
        send_op(OP_ERASE, '0, LEN_W'(BLOCK_BYTES), 8'h00);
        send_op(OP_ERASE, 28'hFFE0000, LEN_W'(MAX_ERASE_BLOCKS * BLOCK_BYTES), 8'hFF);
        send_op(OP_ERASE, 28'hFFFFFFF, LEN_W'(BLOCK_BYTES), 8'h00);
        send_op(OP_ERASE, '0, '0, 8'h00);
        send_op(OP_ERASE, ADDR_W'(BLOCK_BYTES), LEN_W'(BLOCK_BYTES + 1), 8'h00);
        send_op(OP_ERASE, '0, LEN_W'((MAX_ERASE_BLOCKS + 1) * BLOCK_BYTES), 8'h00);
        send_op(OP_ERASE, '0, 29'h1000_0000, 8'h00);
        send_op(OP_BEGIN_READ, '0, '0, 8'h00);
        send_op(OP_BEGIN_PROG, 28'hFFFFFFF, '0, 8'h00);
        send_op(OP_READ_BYTE, '0, '0, 8'h00);
        send_op(OP_WRITE_BYTE, '0, '0, 8'hA5);
        send_op(OP_SPARE_6, 28'hFFFFFFF, 29'h1FFF_FFFF, 8'hFF);
        send_op(OP_SPARE_7, '0, '0, 8'h00);
        // read across a page boundary
        send_op(OP_BEGIN_READ, 28'd2046, 29'd4, 8'h00);
        repeat (4) send_op(OP_READ_BYTE, '0, '0, 8'h00);
        // program across the last page, row wraps to zero
        send_op(OP_BEGIN_PROG, 28'hFFFFFFF, 29'd2, 8'h00);
        send_op(OP_WRITE_BYTE, '0, '0, 8'hFF);
        send_op(OP_WRITE_BYTE, '0, '0, 8'h00);
        // sessions cut short by a new operation
        send_op(OP_BEGIN_READ, 28'd100, 29'd5, 8'h00);
        send_op(OP_READ_BYTE, '0, '0, 8'h00);
        send_op(OP_WRITE_BYTE, '0, '0, 8'h3C);
        send_op(OP_READ_ID, '0, '0, 8'h00);
        send_op(OP_BEGIN_PROG, 28'd4096, 29'd3, 8'h00);
        send_op(OP_WRITE_BYTE, '0, '0, 8'h5A);
        send_op(OP_ERASE, ADDR_W'(BLOCK_BYTES), LEN_W'(BLOCK_BYTES), 8'h00);

        while (counted < ITEMS)
        begin
            calm = (counted >= 300 && counted < 380);
            r = $urandom_range(0, 99);
            if (r < 35)
                run_session(1'b0);
            else if (r < 70)
                run_session(1'b1);
            else if (r < 80)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_op(OP_ERASE, {11'($urandom), 17'h0},
                            LEN_W'($urandom_range(1, MAX_ERASE_BLOCKS) << BLK_SH),
                            8'($urandom));
                else
                    send_op(OP_ERASE, ADDR_W'($urandom),
                            LEN_W'(($urandom_range(0, 12) << BLK_SH)
                                   + $urandom_range(0, 1)),
                            8'($urandom));
                counted++;
            end
            else if (r < 87)
            begin
                send_op(OP_READ_ID, ADDR_W'($urandom), LEN_W'($urandom), 8'($urandom));
                counted++;
            end
            else
                send_op(3'($urandom_range(0, 7)), ADDR_W'($urandom),
                        LEN_W'($urandom_range(0, 1 << 28)), 8'($urandom));
        end
        calm = 1'b0;
        push <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (32) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
